// ----- rtl/fmqd_pkg.sv -----
// Shared types, widths and the CORDIC arctangent table for the FM discriminator.
// Every module of the block imports this package; it depends on nothing else.
package fmqd_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int IN_DATA_WIDTH = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_WIDTH     = 16;
  localparam int GAIN_WIDTH    = 16;
  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 16'd4096;

  // Conjugate product needs 2*SW+1 bits; CORDIC gain and negation need two more.
  localparam int PROD_WIDTH  = 2 * SAMPLE_WIDTH;
  localparam int XY_WIDTH    = 2 * SAMPLE_WIDTH + 3;
  // Angle in units of pi/2^20; magnitude stays below 2^21.
  localparam int Z_WIDTH     = 22;
  localparam int SHIFT_WIDTH = $clog2(CORDIC_STAGES);
  localparam logic signed [Z_WIDTH-1:0] ANGLE_PI = Z_WIDTH'(1048576);

  localparam int SCALE_WIDTH = Z_WIDTH + GAIN_WIDTH + 1;
  localparam int ROUND_SHIFT = 17;

  localparam int ATAN_ENTRIES = 24;
  localparam logic [19:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    20'd262144, 20'd154753, 20'd81767, 20'd41506, 20'd20834, 20'd10427,
    20'd5215,   20'd2608,   20'd1304,  20'd652,   20'd326,   20'd163,
    20'd81,     20'd41,     20'd20,    20'd10,    20'd5,     20'd3,
    20'd1,      20'd1,      20'd0,     20'd0,     20'd0,     20'd0
  };

  // Sideband that travels with each item down the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
    logic zero;
  } fmqd_side_t;

  function automatic logic signed [Z_WIDTH-1:0] cordic_atan(input int unsigned k);
    logic signed [Z_WIDTH-1:0] val;
    val = '0;
    if (k < ATAN_ENTRIES) begin
      val = Z_WIDTH'(ATAN_TABLE[k]);
    end
    return val;
  endfunction

endpackage

// ----- rtl/fmqd_xprod.sv -----
// Conjugate product of the new sample with the previous one, then the
// quadrant fold that sets up the CORDIC. Depends on fmqd_pkg.
module fmqd_xprod (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en,
  input  logic                                     take,
  input  logic                                     last_i,
  input  logic signed [fmqd_pkg::SAMPLE_WIDTH-1:0] i_i,
  input  logic signed [fmqd_pkg::SAMPLE_WIDTH-1:0] q_i,
  output fmqd_pkg::fmqd_side_t                     side_o,
  output logic signed [fmqd_pkg::XY_WIDTH-1:0]     x_o,
  output logic signed [fmqd_pkg::XY_WIDTH-1:0]     y_o,
  output logic signed [fmqd_pkg::Z_WIDTH-1:0]      z_o
);
  import fmqd_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] prev_i_r, prev_q_r;
  logic signed [PROD_WIDTH-1:0]   p_ii_r, p_qq_r, p_qi_r, p_iq_r;
  fmqd_side_t                     side1_r, side2_r;
  logic signed [XY_WIDTH-1:0]     re, im, x_nxt, y_nxt, x_r, y_r;
  logic signed [Z_WIDTH-1:0]      z_nxt, z_r;

  // The previous sample is updated only by an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_i_r <= '0;
      prev_q_r <= '0;
    end else if (take) begin
      prev_i_r <= i_i;
      prev_q_r <= q_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r <= '0;
      side2_r <= '0;
    end else if (en) begin
      side1_r <= '{valid: take, last: last_i, zero: 1'b0};
      side2_r <= '{valid: side1_r.valid, last: side1_r.last, zero: (re == '0) && (im == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ii_r <= PROD_WIDTH'(i_i) * PROD_WIDTH'(prev_i_r);
      p_qq_r <= PROD_WIDTH'(q_i) * PROD_WIDTH'(prev_q_r);
      p_qi_r <= PROD_WIDTH'(q_i) * PROD_WIDTH'(prev_i_r);
      p_iq_r <= PROD_WIDTH'(i_i) * PROD_WIDTH'(prev_q_r);
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
    end
  end

  // A vector in the left half plane is turned by pi toward the right half.
  always_comb begin
    re    = XY_WIDTH'(p_ii_r) + XY_WIDTH'(p_qq_r);
    im    = XY_WIDTH'(p_qi_r) - XY_WIDTH'(p_iq_r);
    x_nxt = re;
    y_nxt = im;
    z_nxt = '0;
    if (re[XY_WIDTH-1]) begin
      x_nxt = -re;
      y_nxt = -im;
      z_nxt = im[XY_WIDTH-1] ? -ANGLE_PI : ANGLE_PI;
    end
  end

  assign side_o = side2_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;

endmodule

// ----- rtl/fmqd_cordic_cell.sv -----
// One vectoring CORDIC micro-rotation with its output registers.
// Shift amount and arctangent step come in as constants. Depends on fmqd_pkg.
module fmqd_cordic_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic [fmqd_pkg::SHIFT_WIDTH-1:0]      shift_i,
  input  logic signed [fmqd_pkg::Z_WIDTH-1:0]   atan_i,
  input  fmqd_pkg::fmqd_side_t                  side_i,
  input  logic signed [fmqd_pkg::XY_WIDTH-1:0]  x_i,
  input  logic signed [fmqd_pkg::XY_WIDTH-1:0]  y_i,
  input  logic signed [fmqd_pkg::Z_WIDTH-1:0]   z_i,
  output fmqd_pkg::fmqd_side_t                  side_o,
  output logic signed [fmqd_pkg::XY_WIDTH-1:0]  x_o,
  output logic signed [fmqd_pkg::XY_WIDTH-1:0]  y_o,
  output logic signed [fmqd_pkg::Z_WIDTH-1:0]   z_o
);
  import fmqd_pkg::*;

  fmqd_side_t                 side_r;
  logic signed [XY_WIDTH-1:0] dx, dy, x_nxt, y_nxt, x_r, y_r;
  logic signed [Z_WIDTH-1:0]  z_nxt, z_r;

  // Rotate toward the positive real axis: clockwise while y is non-negative.
  always_comb begin
    dx = y_i >>> shift_i;
    dy = x_i >>> shift_i;
    if (!y_i[XY_WIDTH-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + atan_i;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - atan_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (en) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign side_o = side_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;

endmodule

// ----- rtl/fmqd_scale.sv -----
// Gain multiply of the angle, round half up and saturation to 16 bits; a zero product gives zero.
// Depends on fmqd_pkg.
module fmqd_scale (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en,
  input  logic [fmqd_pkg::GAIN_WIDTH-1:0]          gain_i,
  input  fmqd_pkg::fmqd_side_t                     side_i,
  input  logic signed [fmqd_pkg::Z_WIDTH-1:0]      z_i,
  output fmqd_pkg::fmqd_side_t                     side_o,
  output logic signed [fmqd_pkg::OUT_WIDTH-1:0]    mpx_o,
  output logic                                     sat_o
);
  import fmqd_pkg::*;

  localparam int QW = SCALE_WIDTH - ROUND_SHIFT;
  localparam logic signed [QW-1:0] Q_MAX = QW'((1 << (OUT_WIDTH - 1)) - 1);
  localparam logic signed [QW-1:0] Q_MIN = -QW'(1 << (OUT_WIDTH - 1));
  localparam logic signed [SCALE_WIDTH-1:0] ROUND_BIAS = SCALE_WIDTH'(1 << (ROUND_SHIFT - 1));

  fmqd_side_t                    side_r;
  logic signed [SCALE_WIDTH-1:0] prod_r, rnd;
  logic signed [QW-1:0]          q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else if (en) begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= SCALE_WIDTH'(z_i) * SCALE_WIDTH'($signed({1'b0, gain_i}));
    end
  end

  always_comb begin
    rnd   = prod_r + ROUND_BIAS;
    q     = $signed(rnd[SCALE_WIDTH-1:ROUND_SHIFT]);
    mpx_o = q[OUT_WIDTH-1:0];
    sat_o = 1'b0;
    if (side_r.zero) begin
      mpx_o = '0;
    end else if (q > Q_MAX) begin
      mpx_o = Q_MAX[OUT_WIDTH-1:0];
      sat_o = 1'b1;
    end else if (q < Q_MIN) begin
      mpx_o = Q_MIN[OUT_WIDTH-1:0];
      sat_o = 1'b1;
    end
  end

  assign side_o = side_r;

endmodule

// ----- rtl/fm_quadrature_discriminator_unit.sv -----
// Top level of the FM quadrature discriminator: conjugate product, CORDIC cell
// chain, gain scaling and an output register with skid. Depends on fmqd_pkg
// and the fmqd_xprod, fmqd_cordic_cell and fmqd_scale modules.
//
//   Channel  Direction  Handshake              Content
//   in_      slave      in_tvalid/in_tready    tdata: i_sample, q_sample; tlast
//   out_     master     out_tvalid/out_tready  tdata: mpx_sample; tuser: saturated; tlast
//   cfg_     write      cfg_wr_en              cfg_wr_data: gain (Q4.12)
//
// One item is accepted per clock while in_tready is high. From acceptance an item
// passes through the product registers, which load at the accepting edge, then
// the quadrant fold register, one register per CORDIC cell, the gain multiply
// register and the output register.
// Reset clears the previous sample to zero, all valid bits and sets gain to 1.0.
// When the output stalls, the item leaving the chain lands in a skid register
// and the whole chain then freezes; in_tready drops only while that skid is full.
module fm_quadrature_discriminator_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [SW-1:0] i_sample, [2*SW-1:SW] q_sample, rest zero fill
  input  logic [fmqd_pkg::IN_DATA_WIDTH-1:0]   in_tdata,
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] mpx_sample
  output logic [fmqd_pkg::OUT_WIDTH-1:0]       out_tdata,
  // [0] saturated
  output logic                                 out_tuser,
  output logic                                 out_tlast,
  input  logic                                 cfg_wr_en,
  input  logic [fmqd_pkg::GAIN_WIDTH-1:0]      cfg_wr_data
);
  import fmqd_pkg::*;

  logic [GAIN_WIDTH-1:0]       gain_r;
  logic                        en;
  logic                        take;

  // Chain taps: index 0 is the fold output, index k+1 the output of cell k.
  fmqd_side_t                  side  [CORDIC_STAGES+1];
  logic signed [XY_WIDTH-1:0]  x_tap [CORDIC_STAGES+1];
  logic signed [XY_WIDTH-1:0]  y_tap [CORDIC_STAGES+1];
  logic signed [Z_WIDTH-1:0]   z_tap [CORDIC_STAGES+1];

  fmqd_side_t                  exit_side;
  logic signed [OUT_WIDTH-1:0] exit_mpx;
  logic                        exit_sat;
  logic                        exit_v;

  logic                        out_v_r, skid_v_r;
  logic [OUT_WIDTH-1:0]        out_data_r, skid_data_r;
  logic                        out_sat_r, skid_sat_r, out_last_r, skid_last_r;
  logic                        out_free;

  // The chain advances whenever the skid register is empty.
  assign en        = !skid_v_r;
  assign in_tready = en;
  assign take      = in_tvalid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain_r <= cfg_wr_data;
    end
  end

  fmqd_xprod u_xprod (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .take   (take),
    .last_i (in_tlast),
    .i_i    ($signed(in_tdata[SAMPLE_WIDTH-1:0])),
    .q_i    ($signed(in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
    .side_o (side[0]),
    .x_o    (x_tap[0]),
    .y_o    (y_tap[0]),
    .z_o    (z_tap[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    fmqd_cordic_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .shift_i (SHIFT_WIDTH'(k)),
      .atan_i  (cordic_atan(k)),
      .side_i  (side[k]),
      .x_i     (x_tap[k]),
      .y_i     (y_tap[k]),
      .z_i     (z_tap[k]),
      .side_o  (side[k+1]),
      .x_o     (x_tap[k+1]),
      .y_o     (y_tap[k+1]),
      .z_o     (z_tap[k+1])
    );
  end

  // The final x and y magnitudes are not needed; only the angle goes on.
  fmqd_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .gain_i (gain_r),
    .side_i (side[CORDIC_STAGES]),
    .z_i    (z_tap[CORDIC_STAGES]),
    .side_o (exit_side),
    .mpx_o  (exit_mpx),
    .sat_o  (exit_sat)
  );

  assign exit_v   = en && exit_side.valid;
  assign out_free = !out_v_r || out_tready;

  // Output slot and skid: the skid fills only when an item leaves the chain
  // while the output slot is held, and it drains first when the slot frees.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r  <= skid_v_r || exit_v;
      skid_v_r <= 1'b0;
    end else if (exit_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) begin
        out_data_r <= skid_data_r;
        out_sat_r  <= skid_sat_r;
        out_last_r <= skid_last_r;
      end else begin
        out_data_r <= exit_mpx;
        out_sat_r  <= exit_sat;
        out_last_r <= exit_side.last;
      end
    end else if (exit_v) begin
      skid_data_r <= exit_mpx;
      skid_sat_r  <= exit_sat;
      skid_last_r <= exit_side.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;
  assign out_tlast  = out_last_r;

  // The skid only ever holds an item behind a held output item.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output slot is empty");

  // The skid register is set only by a stall of the output.
  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_tvalid && !out_tready))
    else $error("skid register filled without an output stall");

  // A clipped result sits at one of the two rails.
  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_tdata == 16'h7fff || out_tdata == 16'h8000))
    else $error("saturation flag set on a value off the rails");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the FM quadrature discriminator top level.
// It depends on fmqd_pkg and fm_quadrature_discriminator_unit only, and reads no files.
// A bit-exact phase predictor checks every item against a queue of pending results.
module testbench;
  import fmqd_pkg::*;

  localparam int CLOCK_HALF      = 10;
  localparam int RESET_CYCLES    = 10;
  localparam int RANDOM_ITEMS    = 1750;
  // The chain is CORDIC_STAGES + 3 deep, plus the output and skid registers; leave a margin.
  localparam int SETTLE_CYCLES   = CORDIC_STAGES + 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int FINAL_PHASE_MAX = 400;

  localparam logic [15:0] GAIN_UNITY = 16'd4096;
  localparam logic [15:0] GAIN_MAX   = 16'd65535;
  localparam logic [15:0] GAIN_ZERO  = 16'd0;

  localparam logic signed [15:0] MPX_POS_RAIL = 16'sd32767;
  localparam logic signed [15:0] MPX_NEG_RAIL = 16'sh8000;
  localparam logic signed [15:0] MPX_ZERO     = 16'sd0;

  // Phase is counted in units of pi/2^20; the arctangent steps are in those units.
  localparam longint HALF_TURN = 64'sd1048576;
  localparam int ARCTAN_STEPS = 24;
  localparam longint ARCTAN_UNITS [ARCTAN_STEPS] = '{
    262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608,
    1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1, 1, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [15:0] mpx;
    logic               sat;
    logic               last;
  } fm_result_t;

  // One row of the directed sequence. A gain write, if any, happens before the item.
  // Rows with typed set carry the expected result; the rest use the predictor.
  typedef struct packed {
    logic               set_gain;
    logic [15:0]        gain_val;
    logic signed [15:0] i_val;
    logic signed [15:0] q_val;
    logic               last;
    logic               typed;
    logic signed [15:0] want_mpx;
    logic               want_sat;
  } probe_row_t;

  localparam int PROBE_COUNT = 22;
  localparam probe_row_t PROBES [PROBE_COUNT] = '{
    // First item after reset: the held sample is zero, so the product is zero.
    '{1'b0, GAIN_ZERO, 16'sd1000, -16'sd2000, 1'b0, 1'b1, MPX_ZERO, 1'b0},
    // A zero sample gives a zero product, twice in a row.
    '{1'b0, GAIN_ZERO, 16'sd0, 16'sd0, 1'b0, 1'b1, MPX_ZERO, 1'b0},
    '{1'b0, GAIN_ZERO, 16'sd0, 16'sd0, 1'b1, 1'b1, MPX_ZERO, 1'b0},
    '{1'b0, GAIN_ZERO, 16'sd16384, 16'sd0, 1'b0, 1'b1, MPX_ZERO, 1'b0},
    // Eighth, quarter and half turns at unity gain; the half turn sits on the rail.
    '{1'b0, GAIN_ZERO, 16'sd16384, 16'sd16384, 1'b0, 1'b0, MPX_ZERO, 1'b0},
    '{1'b0, GAIN_ZERO, 16'sd0, 16'sd16384, 1'b0, 1'b0, MPX_ZERO, 1'b0},
    '{1'b0, GAIN_ZERO, -16'sd16384, 16'sd0, 1'b0, 1'b0, MPX_ZERO, 1'b0},
    '{1'b0, GAIN_ZERO, 16'sd16384, 16'sd0, 1'b0, 1'b0, MPX_ZERO, 1'b0},
    '{1'b0, GAIN_ZERO, 16'sd0, -16'sd16384, 1'b1, 1'b0, MPX_ZERO, 1'b0},
    '{1'b0, GAIN_ZERO, -16'sd1, -16'sd1, 1'b0, 1'b0, MPX_ZERO, 1'b0},
    // Largest gain: the negative real axis maps to +pi and clips high.
    '{1'b1, GAIN_MAX, 16'sd1, 16'sd0, 1'b0, 1'b0, MPX_ZERO, 1'b0},
    '{1'b0, GAIN_ZERO, -16'sd1, 16'sd0, 1'b0, 1'b1, MPX_POS_RAIL, 1'b1},
    '{1'b0, GAIN_ZERO, 16'sd32767, 16'sd0, 1'b0, 1'b1, MPX_POS_RAIL, 1'b1},
    '{1'b0, GAIN_ZERO, 16'sh8000, 16'sd0, 1'b0, 1'b1, MPX_POS_RAIL, 1'b1},
    // Eighth turn from the most negative corner, still far past full scale.
    '{1'b0, GAIN_ZERO, 16'sh8000, 16'sh8000, 1'b0, 1'b1, MPX_POS_RAIL, 1'b1},
    '{1'b0, GAIN_ZERO, 16'sd32767, 16'sh8000, 1'b0, 1'b0, MPX_ZERO, 1'b0},
    // Zero gain squashes any nonzero product to zero without clipping.
    '{1'b1, GAIN_ZERO, 16'sd32767, 16'sd32767, 1'b0, 1'b1, MPX_ZERO, 1'b0},
    '{1'b0, GAIN_ZERO, 16'sh8000, 16'sd32767, 1'b1, 1'b1, MPX_ZERO, 1'b0},
    // Back at unity: a repeated sample, then its negation, then a corner.
    '{1'b1, GAIN_UNITY, 16'sd7, -16'sd3, 1'b0, 1'b0, MPX_ZERO, 1'b0},
    '{1'b0, GAIN_ZERO, 16'sd7, -16'sd3, 1'b0, 1'b0, MPX_ZERO, 1'b0},
    '{1'b0, GAIN_ZERO, -16'sd7, 16'sd3, 1'b0, 1'b0, MPX_ZERO, 1'b0},
    '{1'b0, GAIN_ZERO, 16'sh8000, 16'sh8000, 1'b1, 1'b0, MPX_ZERO, 1'b0}
  };

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [IN_DATA_WIDTH-1:0]   in_tdata;
  logic                       in_tlast;
  logic                       out_tvalid;
  logic                       out_tready;
  logic [OUT_WIDTH-1:0]       out_tdata;
  logic                       out_tuser;
  logic                       out_tlast;
  logic                       cfg_wr_en;
  logic [GAIN_WIDTH-1:0]      cfg_wr_data;

  fm_quadrature_discriminator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #CLOCK_HALF clk = 1'b1;
    #CLOCK_HALF clk = 1'b0;
  end

  // Predictor state: the sample held for the next product and the gain in force.
  logic signed [15:0] held_i;
  logic signed [15:0] held_q;
  logic [15:0]        gain_setting;

  fm_result_t pending_results [$];

  // Idling controls shared by the sender and the receiver.
  bit gaps_on;
  bit hold_off_req;

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned saturations;
  int unsigned gain_writes;
  int unsigned input_stall_cycles;
  int unsigned cycle_count;

  // Random tone that stands in for a real FM signal: amplitude, phase, step.
  real tone_phase;
  real tone_step;
  int  tone_amp;
  int  tone_left;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0d] mismatch: %s", cycle_count, msg);
  endtask

  // Conjugate product, vectoring CORDIC, gain with round half up, then clip.
  // Also moves the current sample into the held slot.
  function automatic void discriminate(input logic signed [15:0] cur_i,
                                       input logic signed [15:0] cur_q,
                                       output logic signed [15:0] mpx,
                                       output logic sat);
    longint re, im, x, y, z, dx, dy, gl, scaled;
    re = longint'(cur_i) * longint'(held_i) + longint'(cur_q) * longint'(held_q);
    im = longint'(cur_q) * longint'(held_i) - longint'(cur_i) * longint'(held_q);
    mpx = MPX_ZERO;
    sat = 1'b0;
    if (re != 0 || im != 0) begin
      x = re;
      y = im;
      z = 0;
      // Left half plane: turn the vector by a half turn first.
      if (re < 0) begin
        x = -re;
        y = -im;
        z = (im >= 0) ? HALF_TURN : -HALF_TURN;
      end
      for (int k = 0; k < CORDIC_STAGES && k < ARCTAN_STEPS; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ARCTAN_UNITS[k];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ARCTAN_UNITS[k];
        end
      end
      gl = gain_setting;
      scaled = (z * gl + 64'sd65536) >>> 17;
      if (scaled > 32767) begin
        mpx = MPX_POS_RAIL;
        sat = 1'b1;
      end else if (scaled < -32768) begin
        mpx = MPX_NEG_RAIL;
        sat = 1'b1;
      end else begin
        mpx = 16'(scaled);
      end
    end
    held_i = cur_i;
    held_q = cur_q;
  endfunction

  function automatic logic signed [15:0] to_sample(input real v);
    int r;
    r = $rtoi(v);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // Offers one item, waits for it to be taken, then queues what it must produce.
  // A typed expectation overrides the predicted fields but the predictor still runs,
  // so the held sample stays in step with the block.
  task automatic send_item(input logic signed [15:0] si, input logic signed [15:0] sq,
                           input logic lst, input logic typed,
                           input logic signed [15:0] typed_mpx, input logic typed_sat);
    fm_result_t predicted;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_WIDTH'({sq, si});
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    discriminate(si, sq, predicted.mpx, predicted.sat);
    predicted.last = lst;
    if (typed) begin
      predicted.mpx = typed_mpx;
      predicted.sat = typed_sat;
    end
    pending_results.push_back(predicted);
    items_sent++;
  endtask

  // The gain only changes with the block drained and idle.
  task automatic write_gain(input logic [15:0] value);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gain_setting = value;
    gain_writes++;
  endtask

  // Most random items continue a wandering tone, which is what the block sees in use.
  // The rest are raw noise, repeats, negations, conjugates and swaps of the last sample,
  // corners, zeros and tiny vectors.
  task automatic make_random_item(output logic signed [15:0] si,
                                  output logic signed [15:0] sq, output logic lst);
    int pick;
    logic signed [15:0] corner [6];
    corner = '{16'sh8000, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    pick = $urandom_range(0, 99);
    lst = ($urandom_range(0, 7) == 0);
    if (tone_left == 0) begin
      tone_amp  = $urandom_range(1, 32767);
      tone_step = (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0 * 3.14159;
      tone_left = $urandom_range(8, 64);
    end
    if (pick < 62) begin
      tone_phase = tone_phase + tone_step + (real'($urandom_range(0, 200)) - 100.0) / 1000.0;
      si = to_sample(tone_amp * $cos(tone_phase));
      sq = to_sample(tone_amp * $sin(tone_phase));
      tone_left--;
    end else if (pick < 77) begin
      si = 16'($urandom);
      sq = 16'($urandom);
    end else if (pick < 84) begin
      case ($urandom_range(0, 3))
        0: begin
          si = held_i;
          sq = held_q;
        end
        1: begin
          si = -held_i;
          sq = -held_q;
        end
        2: begin
          si = held_i;
          sq = -held_q;
        end
        default: begin
          si = held_q;
          sq = held_i;
        end
      endcase
    end else if (pick < 91) begin
      si = corner[$urandom_range(0, 5)];
      sq = corner[$urandom_range(0, 5)];
    end else if (pick < 95) begin
      si = 16'sd0;
      sq = 16'sd0;
    end else begin
      si = 16'($signed($urandom_range(0, 8)) - 4);
      sq = 16'($signed($urandom_range(0, 8)) - 4);
    end
  endtask

  // Receiver side: random stall bursts, one long hold-off on request, then steady.
  initial begin : sink_ready
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Every accepted result is matched against the oldest pending one.
  always @(posedge clk) begin : result_check
    fm_result_t want;
    if (rst_n) begin
      if (in_tvalid && !in_tready) input_stall_cycles++;
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none pending",
                                    $signed(out_tdata)));
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (want.sat) saturations++;
          if (out_tdata !== want.mpx)
            report_mismatch($sformatf("mpx_sample got %0d want %0d",
                                      $signed(out_tdata), want.mpx));
          if (out_tuser !== want.sat)
            report_mismatch($sformatf("saturated got %b want %b", out_tuser, want.sat));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last got %b want %b", out_tlast, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results pending",
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    logic signed [15:0] si;
    logic signed [15:0] sq;
    logic               lst;
    int                 remaining;
    int                 phase_len;
    int                 phase_idx;
    logic [15:0]        next_gain;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    held_i       = 16'sd0;
    held_q       = 16'sd0;
    gain_setting = GAIN_UNITY;
    gaps_on      = 1'b1;
    hold_off_req = 1'b0;
    tone_phase   = 0.0;
    tone_step    = 0.0;
    tone_amp     = 0;
    tone_left    = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: reset state, zero products, axis cases and the gain extremes.
    for (int r = 0; r < PROBE_COUNT; r++) begin
      if (PROBES[r].set_gain) write_gain(PROBES[r].gain_val);
      send_item(PROBES[r].i_val, PROBES[r].q_val, PROBES[r].last,
                PROBES[r].typed, PROBES[r].want_mpx, PROBES[r].want_sat);
    end

    // Random phases, each under its own gain. The first few pin the extremes;
    // the third also holds the receiver off long enough to back up the input.
    // The final phase runs without idling on either side.
    remaining = RANDOM_ITEMS;
    phase_idx = 0;
    while (remaining > 0) begin
      phase_len = (remaining <= FINAL_PHASE_MAX) ? remaining : $urandom_range(120, 260);
      case (phase_idx)
        0: next_gain = GAIN_MAX;
        1: next_gain = GAIN_ZERO;
        2: next_gain = GAIN_UNITY;
        3: next_gain = 16'd1;
        default: begin
          if ($urandom_range(0, 3) == 0) next_gain = 16'($urandom_range(0, 65535));
          else next_gain = 16'($urandom_range(1024, 12288));
        end
      endcase
      write_gain(next_gain);
      if (phase_len == remaining) gaps_on = 1'b0;
      if (phase_idx == 2) hold_off_req = 1'b1;
      for (int n = 0; n < phase_len; n++) begin
        make_random_item(si, sq, lst);
        send_item(si, sq, lst, 1'b0, MPX_ZERO, 1'b0);
      end
      remaining = remaining - phase_len;
      phase_idx++;
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples (%0d directed) under %0d gain settings; %0d results checked.",
             items_sent, PROBE_COUNT, gain_writes, results_checked);
    $display("%0d results clipped; input backed up for %0d cycles; %0d mismatches.",
             saturations, input_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
